>>> rtl/text_cursor_controller_unit_assert.svh
// ----------------------------------------------------------------------------
// Text cursor controller - assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// switched off while the synchronous reset is held.
// ----------------------------------------------------------------------------
`ifndef TEXT_CURSOR_CONTROLLER_UNIT_ASSERT_SVH
`define TEXT_CURSOR_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication
`define TCCU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TCCU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tccu_pkg.sv
// ----------------------------------------------------------------------------
// Text cursor controller - package
// Types, codes and constants shared by the controller modules.
// ----------------------------------------------------------------------------
package tccu_pkg;

    // Field widths
    localparam int CODE_W   = 16;
    localparam int CELL_W   = 8;
    localparam int PIX_W    = 13;
    localparam int OFF_W    = 12;
    localparam int GLYPH_W  = 6;
    localparam int DIM_W    = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 9;

    // Result burst limit and its counter width
    localparam int MAX_RESULTS = 8;
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    // Default tab expansion
    localparam int TAB_SPACES_DEF = 4;

    // Largest usable screen dimension
    localparam logic [DIM_W-1:0] DIM_MAX = 9'd256;

    // Configuration reset values
    localparam logic [GLYPH_W-1:0] RST_GLYPH_WIDTH  = 6'd8;
    localparam logic [GLYPH_W-1:0] RST_GLYPH_HEIGHT = 6'd16;
    localparam logic [DIM_W-1:0]   RST_TEXT_COLUMNS = 9'd80;
    localparam logic [DIM_W-1:0]   RST_TEXT_ROWS    = 9'd25;

    // Character codes
    localparam logic [6:0] CH_BACKSPACE = 7'h08;
    localparam logic [6:0] CH_TAB       = 7'h09;
    localparam logic [6:0] CH_NEWLINE   = 7'h0A;
    localparam logic [6:0] CH_CR        = 7'h0D;
    localparam logic [6:0] CH_SPACE     = 7'h20;
    localparam logic [6:0] CH_QMARK     = 7'h3F;
    localparam logic [CODE_W-1:0] CODE_BYTE_MAX = 16'd255;

    typedef enum logic [1:0] {
        KIND_PUT_CURSOR = 2'd0,
        KIND_PUT_CELL   = 2'd1,
        KIND_SET_CURSOR = 2'd2,
        KIND_CLEAR      = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CMD_DRAW   = 2'd0,
        CMD_SCROLL = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_STATUS = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_BAD_LOC  = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GLYPH_WIDTH  = 3'd0,
        REG_GLYPH_HEIGHT = 3'd1,
        REG_TEXT_COLUMNS = 3'd2,
        REG_TEXT_ROWS    = 3'd3
    } t_reg_idx;

    // Sequencer phase of the item in flight
    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_TAB    = 2'd1,
        PH_SCROLL = 2'd2
    } t_phase;

    // Active configuration, with screen dimensions already clamped
    typedef struct packed {
        logic [GLYPH_W-1:0] glyph_width;
        logic [GLYPH_W-1:0] glyph_height;
        logic [DIM_W-1:0]   eff_cols;
        logic [DIM_W-1:0]   eff_rows;
    } t_cfg;

    // Sequencer control carried between steps of one item
    typedef struct packed {
        t_phase            phase;
        logic              tab_mode;
        logic [NRES_W-1:0] nres;
    } t_seq_ctl;

    // One result beat
    typedef struct packed {
        t_cmd              command;
        logic [PIX_W-1:0]  pixel_x;
        logic [PIX_W-1:0]  pixel_y;
        logic [OFF_W-1:0]  glyph_offset;
        t_status           status;
        logic [CELL_W-1:0] cursor_col_out;
        logic [CELL_W-1:0] cursor_row_out;
        logic              last;
    } t_result;

endpackage

>>> rtl/tccu_ifs.sv
// ----------------------------------------------------------------------------
// Text cursor controller - channel interfaces
// Request, result and register-write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface tccu_item_if import tccu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [CODE_W-1:0] char_code;
    logic [CELL_W-1:0] cell_col;
    logic [CELL_W-1:0] cell_row;

    modport source (output valid, kind, char_code, cell_col, cell_row, input ready);
    modport sink   (input valid, kind, char_code, cell_col, cell_row, output ready);
endinterface

interface tccu_res_if import tccu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic [PIX_W-1:0]  pixel_x;
    logic [PIX_W-1:0]  pixel_y;
    logic [OFF_W-1:0]  glyph_offset;
    logic [1:0]        status;
    logic [CELL_W-1:0] cursor_col_out;
    logic [CELL_W-1:0] cursor_row_out;
    logic              last;

    modport source (output valid, command, pixel_x, pixel_y, glyph_offset, status,
                    cursor_col_out, cursor_row_out, last, input ready);
    modport sink   (input valid, command, pixel_x, pixel_y, glyph_offset, status,
                    cursor_col_out, cursor_row_out, last, output ready);
endinterface

interface tccu_cfg_if import tccu_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/tccu_cfg_regs.sv
// ----------------------------------------------------------------------------
// Text cursor controller - configuration registers
// Holds glyph size and screen size, and clamps the screen size to 256.
// ----------------------------------------------------------------------------
module tccu_cfg_regs import tccu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tccu_cfg_if.sink   i_cfg,
    output t_cfg       o_cfg
);

    logic [GLYPH_W-1:0] r_glyph_width;
    logic [GLYPH_W-1:0] r_glyph_height;
    logic [DIM_W-1:0]   r_text_columns;
    logic [DIM_W-1:0]   r_text_rows;

    // Always take a write beat
    assign i_cfg.ready = 1'b1;

    // Decode the register index; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph_width  <= RST_GLYPH_WIDTH;
            r_glyph_height <= RST_GLYPH_HEIGHT;
            r_text_columns <= RST_TEXT_COLUMNS;
            r_text_rows    <= RST_TEXT_ROWS;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_GLYPH_WIDTH:  r_glyph_width  <= i_cfg.data[GLYPH_W-1:0];
                REG_GLYPH_HEIGHT: r_glyph_height <= i_cfg.data[GLYPH_W-1:0];
                REG_TEXT_COLUMNS: r_text_columns <= i_cfg.data[DIM_W-1:0];
                REG_TEXT_ROWS:    r_text_rows    <= i_cfg.data[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clamp the screen to the cursor's reach
    always_comb begin
        o_cfg.glyph_width  = r_glyph_width;
        o_cfg.glyph_height = r_glyph_height;
        o_cfg.eff_cols     = (r_text_columns > DIM_MAX) ? DIM_MAX : r_text_columns;
        o_cfg.eff_rows     = (r_text_rows > DIM_MAX) ? DIM_MAX : r_text_rows;
    end

endmodule

>>> rtl/tccu_step.sv
// ----------------------------------------------------------------------------
// Text cursor controller - step logic
// Works out one result beat of the item in flight, the cursor after it and
// the sequencer control for the next beat.
// ----------------------------------------------------------------------------
module tccu_step import tccu_pkg::*; #(
    parameter int TAB_SPACES = TAB_SPACES_DEF,
    parameter int SP_W       = $clog2(TAB_SPACES + 1)
) (
    input  t_cfg              i_cfg,
    input  t_seq_ctl          i_ctl,
    input  logic [SP_W-1:0]   i_spaces,
    input  t_kind             i_kind,
    input  logic [CODE_W-1:0] i_code,
    input  logic [CELL_W-1:0] i_cell_col,
    input  logic [CELL_W-1:0] i_cell_row,
    input  logic [CELL_W-1:0] i_cur_col,
    input  logic [CELL_W-1:0] i_cur_row,
    output t_result           o_res,
    output t_seq_ctl          o_ctl,
    output logic [SP_W-1:0]   o_spaces
);

    logic              code_big;
    logic              char_bad;
    logic [6:0]        code_eff;
    logic [CELL_W-1:0] x;
    logic [CELL_W-1:0] y;
    logic              loc_bad;
    logic              is_put;
    logic              put_ok;
    logic              is_ctrl;
    logic              tab_start;
    logic              is_draw;
    logic [CELL_W-1:0] dx;
    logic [CELL_W-1:0] dy;
    logic [6:0]        dcode;
    logic              wrap;
    logic              bottom;
    logic [CELL_W-1:0] d_col;
    logic [CELL_W-1:0] d_row;
    logic              d_scroll;
    logic [DIM_W-1:0]  x_inc;
    logic [DIM_W-1:0]  y_inc;
    logic [CELL_W-1:0] last_row;
    logic [PIX_W:0]    prod_x;
    logic [PIX_W:0]    prod_y;
    logic [PIX_W-1:0]  prod_off;
    logic [NRES_W:0]   nres_room;
    logic [NRES_W-1:0] nres_after;
    logic [SP_W-1:0]   spaces_after;
    logic              tab_after;
    logic              can_space;
    logic              more;

    // Classify the item and pick the draw operands
    always_comb begin
        code_big  = (i_code > CODE_BYTE_MAX);
        char_bad  = !code_big && i_code[7];
        code_eff  = code_big ? CH_QMARK : i_code[6:0];
        x         = (i_kind == KIND_PUT_CURSOR) ? i_cur_col : i_cell_col;
        y         = (i_kind == KIND_PUT_CURSOR) ? i_cur_row : i_cell_row;
        loc_bad   = ({1'b0, x} >= i_cfg.eff_cols) || ({1'b0, y} >= i_cfg.eff_rows);
        is_put    = (i_kind == KIND_PUT_CURSOR) || (i_kind == KIND_PUT_CELL);
        put_ok    = is_put && !char_bad && !loc_bad;
        is_ctrl   = (code_eff == CH_NEWLINE) || (code_eff == CH_BACKSPACE)
                    || (code_eff == CH_CR);
        tab_start = (i_ctl.phase == PH_FIRST) && put_ok && (code_eff == CH_TAB);
        is_draw   = (i_ctl.phase == PH_TAB)
                    || ((i_ctl.phase == PH_FIRST) && put_ok && !is_ctrl);

        if (i_ctl.phase == PH_FIRST) begin
            dx    = x;
            dy    = y;
            dcode = (code_eff == CH_TAB) ? CH_SPACE : code_eff;
        end else begin
            dx    = i_cur_col;
            dy    = i_cur_row;
            dcode = CH_SPACE;
        end

        // Advance with wrap and scroll
        x_inc    = {1'b0, dx} + 9'd1;
        y_inc    = {1'b0, dy} + 9'd1;
        last_row = CELL_W'(i_cfg.eff_rows - 9'd1);
        wrap     = (x_inc >= i_cfg.eff_cols);
        bottom   = (y_inc >= i_cfg.eff_rows);
        d_scroll = wrap && bottom;
        d_col    = wrap ? '0 : x_inc[CELL_W-1:0];
        if (!wrap) begin
            d_row = dy;
        end else if (bottom) begin
            d_row = last_row;
        end else begin
            d_row = y_inc[CELL_W-1:0];
        end

        // Glyph placement
        prod_x   = (PIX_W+1)'(dx * i_cfg.glyph_width);
        prod_y   = (PIX_W+1)'(dy * i_cfg.glyph_height);
        prod_off = PIX_W'(dcode * i_cfg.glyph_height);
    end

    // Next sequencer state
    always_comb begin
        nres_after = i_ctl.nres + NRES_W'(1);
        nres_room  = {1'b0, nres_after} + (NRES_W+1)'(2);
        if (tab_start) begin
            spaces_after = SP_W'(TAB_SPACES - 1);
        end else if (i_ctl.phase == PH_TAB) begin
            spaces_after = i_spaces - SP_W'(1);
        end else begin
            spaces_after = i_spaces;
        end
        tab_after = tab_start || ((i_ctl.phase != PH_FIRST) && i_ctl.tab_mode);
        can_space = tab_after && (spaces_after != '0)
                    && (nres_room <= (NRES_W+1)'(MAX_RESULTS));

        if (is_draw && d_scroll) begin
            more        = 1'b1;
            o_ctl.phase = PH_SCROLL;
        end else if ((is_draw || (i_ctl.phase == PH_SCROLL)) && can_space) begin
            more        = 1'b1;
            o_ctl.phase = PH_TAB;
        end else begin
            more        = 1'b0;
            o_ctl.phase = PH_FIRST;
        end
        o_ctl.tab_mode = tab_after;
        o_ctl.nres     = nres_after;
        o_spaces       = spaces_after;
    end

    // Result beat and cursor after it
    always_comb begin
        o_res.command        = CMD_STATUS;
        o_res.pixel_x        = '0;
        o_res.pixel_y        = '0;
        o_res.glyph_offset   = '0;
        o_res.status         = ST_OK;
        o_res.cursor_col_out = i_cur_col;
        o_res.cursor_row_out = i_cur_row;
        o_res.last           = !more;

        if (is_draw) begin
            o_res.command        = CMD_DRAW;
            o_res.pixel_x        = prod_x[PIX_W-1:0];
            o_res.pixel_y        = prod_y[PIX_W-1:0];
            o_res.glyph_offset   = prod_off[OFF_W-1:0];
            o_res.cursor_col_out = d_col;
            o_res.cursor_row_out = d_row;
        end else if (i_ctl.phase == PH_SCROLL) begin
            o_res.command = CMD_SCROLL;
        end else if (i_kind == KIND_CLEAR) begin
            o_res.command        = CMD_CLEAR;
            o_res.cursor_col_out = '0;
            o_res.cursor_row_out = '0;
        end else if (i_kind == KIND_SET_CURSOR) begin
            if (loc_bad) begin
                o_res.status = ST_BAD_LOC;
            end else begin
                o_res.cursor_col_out = i_cell_col;
                o_res.cursor_row_out = i_cell_row;
            end
        end else if (char_bad) begin
            o_res.status = ST_BAD_CHAR;
        end else if (loc_bad) begin
            o_res.status = ST_BAD_LOC;
        end else begin
            // Control codes that move the cursor without drawing
            case (code_eff)
                CH_NEWLINE: begin
                    o_res.cursor_col_out = '0;
                    if (bottom) begin
                        o_res.cursor_row_out = last_row;
                        o_res.command        = CMD_SCROLL;
                    end else begin
                        o_res.cursor_row_out = y_inc[CELL_W-1:0];
                    end
                end
                CH_BACKSPACE: begin
                    if (x != '0) begin
                        o_res.cursor_col_out = x - CELL_W'(1);
                        o_res.cursor_row_out = y;
                    end else if (y != '0) begin
                        o_res.cursor_col_out = CELL_W'(i_cfg.eff_cols - 9'd1);
                        o_res.cursor_row_out = y - CELL_W'(1);
                    end else begin
                        o_res.cursor_col_out = '0;
                        o_res.cursor_row_out = '0;
                    end
                end
                default: begin
                    // Carriage return
                    o_res.cursor_col_out = '0;
                    o_res.cursor_row_out = y;
                end
            endcase
        end
    end

endmodule

>>> rtl/text_cursor_controller_unit.sv
// ----------------------------------------------------------------------------
// Text cursor controller - top level
// Text console cursor controller: turns character requests into draw,
// scroll and clear commands and tracks the cursor cell.
// ----------------------------------------------------------------------------
// Usage:
//   i_item  request beats: kind, char_code, cell_col, cell_row.
//   o_res   result beats: command, pixel_x/y, glyph_offset, status, cursor
//           after the beat, and last on the final beat of each request.
//   i_cfg   register writes (glyph width/height, columns, rows); always
//           ready, to be written only while no request is outstanding.
// Order: a request is taken into the request register, and its first
//   result is then registered in the output register once that is free or draining.
// Throughput: one result beat per cycle from the single-pass step logic
//   while the output is not held. Plain requests give one beat, so one
//   request per cycle; a draw that scrolls gives two beats; a tab gives
//   up to 2 * TAB_SPACES beats, capped at 8 beats.
// Stall: a held result keeps its beat; the next request is taken in the
//   same cycle as the current one retires its last beat into the output
//   register.
// Reset: cursor to (0,0), registers to 8x16 glyphs on 80x25 cells, all
//   channels empty.
// ----------------------------------------------------------------------------
`include "text_cursor_controller_unit_assert.svh"

module text_cursor_controller_unit import tccu_pkg::*; #(
    parameter int TAB_SPACES = TAB_SPACES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tccu_item_if.sink i_item,
    tccu_res_if.source o_res,
    tccu_cfg_if.sink  i_cfg
);

    localparam int SP_W = $clog2(TAB_SPACES + 1);

    t_cfg              cfg;
    logic              r_act;
    t_seq_ctl          r_ctl;
    logic [SP_W-1:0]   r_spaces;
    t_kind             r_kind;
    logic [CODE_W-1:0] r_code;
    logic [CELL_W-1:0] r_cell_col;
    logic [CELL_W-1:0] r_cell_row;
    logic [CELL_W-1:0] r_cur_col;
    logic [CELL_W-1:0] r_cur_row;
    t_result           r_res;
    logic              r_ovalid;
    t_result           n_res;
    t_seq_ctl          n_ctl;
    logic [SP_W-1:0]   n_spaces;
    logic              load_ok;
    logic              step_fire;
    logic              in_fire;

    tccu_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    tccu_step #(
        .TAB_SPACES (TAB_SPACES),
        .SP_W       (SP_W)
    ) u_step (
        .i_cfg      (cfg),
        .i_ctl      (r_ctl),
        .i_spaces   (r_spaces),
        .i_kind     (r_kind),
        .i_code     (r_code),
        .i_cell_col (r_cell_col),
        .i_cell_row (r_cell_row),
        .i_cur_col  (r_cur_col),
        .i_cur_row  (r_cur_row),
        .o_res      (n_res),
        .o_ctl      (n_ctl),
        .o_spaces   (n_spaces)
    );

    // Handshake: step when the output register is free or draining
    assign load_ok      = !r_ovalid || o_res.ready;
    assign step_fire    = r_act && load_ok;
    assign i_item.ready = !r_act || (step_fire && n_res.last);
    assign in_fire      = i_item.valid && i_item.ready;

    // Request register and sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= 1'b0;
            r_ctl    <= '{phase: PH_FIRST, tab_mode: 1'b0, nres: '0};
            r_spaces <= '0;
        end else if (in_fire) begin
            r_act    <= 1'b1;
            r_ctl    <= '{phase: PH_FIRST, tab_mode: 1'b0, nres: '0};
            r_spaces <= '0;
        end else if (step_fire) begin
            r_act    <= !n_res.last;
            r_ctl    <= n_ctl;
            r_spaces <= n_spaces;
        end
    end

    // Capture the request payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind     <= t_kind'(i_item.kind);
            r_code     <= i_item.char_code;
            r_cell_col <= i_item.cell_col;
            r_cell_row <= i_item.cell_row;
        end
    end

    // Cursor follows every beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col <= '0;
            r_cur_row <= '0;
        end else if (step_fire) begin
            r_cur_col <= n_res.cursor_col_out;
            r_cur_row <= n_res.cursor_row_out;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (step_fire) begin
            r_ovalid <= 1'b1;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid          = r_ovalid;
    assign o_res.command        = r_res.command;
    assign o_res.pixel_x        = r_res.pixel_x;
    assign o_res.pixel_y        = r_res.pixel_y;
    assign o_res.glyph_offset   = r_res.glyph_offset;
    assign o_res.status         = r_res.status;
    assign o_res.cursor_col_out = r_res.cursor_col_out;
    assign o_res.cursor_row_out = r_res.cursor_row_out;
    assign o_res.last           = r_res.last;

    // Assertions
    `TCCU_ASSERT_IMP(a_burst_bound, i_clk, i_rst_n, r_act, r_ctl.nres < NRES_W'(MAX_RESULTS), "result burst exceeds limit")
    `TCCU_ASSERT_IMP(a_scroll_after_draw, i_clk, i_rst_n, r_act && (r_ctl.phase == PH_SCROLL), r_ovalid && (r_res.command == CMD_DRAW) && !r_res.last, "pending scroll without a preceding draw")
    `TCCU_ASSERT_IMP(a_status_on_last, i_clk, i_rst_n, r_ovalid && !r_res.last, r_res.status == ST_OK, "error status on a non-final beat")
    `TCCU_ASSERT_IMP(a_scroll_bottom, i_clk, i_rst_n, r_ovalid && (r_res.command == CMD_SCROLL), r_res.cursor_row_out == CELL_W'(cfg.eff_rows - 9'd1), "scroll with cursor off the bottom row")
    `TCCU_ASSERT_NXT(a_cursor_follows, i_clk, i_rst_n, step_fire, (r_cur_col == r_res.cursor_col_out) && (r_cur_row == r_res.cursor_row_out), "cursor differs from last result beat")

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text cursor controller - testbench
// Drives request beats and register writes into the cursor controller and
// checks every result beat against a cycle-free prediction of the console.
// The prediction keeps its own cursor and screen settings. A directed
// opening covers the control codes, the rejected codes and cells, and wrap
// with scroll. Random requests then run under several screen settings,
// from 1x1 cells up to over-range values and zero-sized screens. Both
// channels idle at random, and the result side holds off for a long
// stretch once to back the block up.
// ----------------------------------------------------------------------------
module testbench;
    import tccu_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 20;
    localparam int CODE_ASCII_END = 128;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // ------------------------------------------------------------------------
    // Console model: cursor, screen settings and the queue of expected beats
    // ------------------------------------------------------------------------
    class cursor_tracker;
        logic [GLYPH_W-1:0] glyph_w, glyph_h;
        logic [DIM_W-1:0]   cols, rows;
        logic [CELL_W-1:0]  cur_col, cur_row;
        t_result            expected_beats[$];
        int                 n_errors, n_items, n_beats, n_writes;

        function new();
            glyph_w  = RST_GLYPH_WIDTH;
            glyph_h  = RST_GLYPH_HEIGHT;
            cols     = RST_TEXT_COLUMNS;
            rows     = RST_TEXT_ROWS;
            cur_col  = '0;
            cur_row  = '0;
            n_errors = 0;
            n_items  = 0;
            n_beats  = 0;
            n_writes = 0;
        endfunction

        function int visible_cols();
            return (cols > DIM_MAX) ? int'(DIM_MAX) : int'(cols);
        endfunction

        function int visible_rows();
            return (rows > DIM_MAX) ? int'(DIM_MAX) : int'(rows);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            n_writes++;
            case (idx)
                REG_GLYPH_WIDTH:  glyph_w = data[GLYPH_W-1:0];
                REG_GLYPH_HEIGHT: glyph_h = data[GLYPH_W-1:0];
                REG_TEXT_COLUMNS: cols    = data;
                REG_TEXT_ROWS:    rows    = data;
                default: ;
            endcase
        endfunction

        // Queue one beat carrying the cursor as it stands now
        function void push_beat(t_cmd cmd, int px, int py, int off);
            t_result r;
            r.command        = cmd;
            r.pixel_x        = PIX_W'(px);
            r.pixel_y        = PIX_W'(py);
            r.glyph_offset   = OFF_W'(off);
            r.status         = ST_OK;
            r.cursor_col_out = cur_col;
            r.cursor_row_out = cur_row;
            r.last           = 1'b0;
            expected_beats.push_back(r);
        endfunction

        // Draw at a cell known to be on screen, then advance, wrap and scroll
        function void draw_glyph(int code, int x, int y);
            int ec, er;
            bit scroll;
            ec     = visible_cols();
            er     = visible_rows();
            scroll = 1'b0;
            if (x + 1 >= ec) begin
                cur_col = '0;
                if (y + 1 >= er) begin
                    cur_row = CELL_W'(er - 1);
                    scroll  = 1'b1;
                end else begin
                    cur_row = CELL_W'(y + 1);
                end
            end else begin
                cur_col = CELL_W'(x + 1);
                cur_row = CELL_W'(y);
            end
            push_beat(CMD_DRAW, x * int'(glyph_w), y * int'(glyph_h), code * int'(glyph_h));
            if (scroll)
                push_beat(CMD_SCROLL, 0, 0, 0);
        endfunction

        function t_status put_char(int code, int x, int y);
            int ec, er, base;
            ec   = visible_cols();
            er   = visible_rows();
            base = expected_beats.size();
            // Wide codes fall back to a question mark; upper byte codes are refused
            if (code > int'(CODE_BYTE_MAX))
                code = int'(CH_QMARK);
            else if (code >= CODE_ASCII_END)
                return ST_BAD_CHAR;
            if (x >= ec || y >= er)
                return ST_BAD_LOC;
            case (code)
                CH_NEWLINE: begin
                    cur_col = '0;
                    if (y + 1 >= er) begin
                        cur_row = CELL_W'(er - 1);
                        push_beat(CMD_SCROLL, 0, 0, 0);
                    end else begin
                        cur_row = CELL_W'(y + 1);
                    end
                end
                CH_BACKSPACE: begin
                    if (x == 0) begin
                        if (y != 0) begin
                            cur_row = CELL_W'(y - 1);
                            cur_col = CELL_W'(ec - 1);
                        end else begin
                            cur_row = '0;
                            cur_col = '0;
                        end
                    end else begin
                        cur_col = CELL_W'(x - 1);
                        cur_row = CELL_W'(y);
                    end
                end
                CH_CR: begin
                    cur_col = '0;
                    cur_row = CELL_W'(y);
                end
                CH_TAB: begin
                    cur_col = CELL_W'(x);
                    cur_row = CELL_W'(y);
                    // Drop spaces once a draw plus scroll would no longer fit
                    for (int i = 0; i < TAB_SPACES_DEF &&
                         expected_beats.size() - base + 2 <= MAX_RESULTS; i++)
                        draw_glyph(CH_SPACE, cur_col, cur_row);
                end
                default: draw_glyph(code, x, y);
            endcase
            return ST_OK;
        endfunction

        // Work out every beat that one accepted request causes
        function void take_request(logic [1:0] kind, logic [CODE_W-1:0] code,
                                   logic [CELL_W-1:0] col, logic [CELL_W-1:0] row);
            int base;
            t_status st;
            t_result tail;
            base = expected_beats.size();
            st   = ST_OK;
            n_items++;
            case (kind)
                KIND_PUT_CURSOR: st = put_char(code, cur_col, cur_row);
                KIND_PUT_CELL:   st = put_char(code, col, row);
                KIND_SET_CURSOR: begin
                    if (col >= visible_cols() || row >= visible_rows()) begin
                        st = ST_BAD_LOC;
                    end else begin
                        cur_col = col;
                        cur_row = row;
                    end
                end
                default: begin
                    cur_col = '0;
                    cur_row = '0;
                    push_beat(CMD_CLEAR, 0, 0, 0);
                end
            endcase
            if (expected_beats.size() == base)
                push_beat(CMD_STATUS, 0, 0, 0);
            tail        = expected_beats.pop_back();
            tail.status = st;
            tail.last   = 1'b1;
            expected_beats.push_back(tail);
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        task report(string msg);
            n_errors++;
            if (n_errors <= 20)
                $display("[%0t] mismatch on beat %0d: %s", $time, n_beats, msg);
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("%s is %0h, expected %0h", name, got, want));
        endtask

        task check_beat(t_result got);
            t_result want;
            n_beats++;
            if (expected_beats.size() == 0) begin
                report("result beat with nothing outstanding");
            end else begin
                want = expected_beats.pop_front();
                compare_field("command", 16'(got.command), 16'(want.command));
                compare_field("pixel_x", 16'(got.pixel_x), 16'(want.pixel_x));
                compare_field("pixel_y", 16'(got.pixel_y), 16'(want.pixel_y));
                compare_field("glyph_offset", 16'(got.glyph_offset),
                              16'(want.glyph_offset));
                compare_field("status", 16'(got.status), 16'(want.status));
                compare_field("cursor_col_out", 16'(got.cursor_col_out),
                              16'(want.cursor_col_out));
                compare_field("cursor_row_out", 16'(got.cursor_row_out),
                              16'(want.cursor_row_out));
                compare_field("last", 16'(got.last), 16'(want.last));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    int   n_cycles;
    bit   fast_send;
    bit   fast_take;
    bit   hold_request;
    int   n_settings;

    cursor_tracker tracker;
    t_result       seen;

    tccu_item_if item_ch ();
    tccu_res_if  res_ch ();
    tccu_cfg_if  cfg_ch ();

    text_cursor_controller_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Run limit
    initial n_cycles = 0;
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("FAIL text_cursor_controller_unit");
            $finish;
        end
    end

    // Check every result beat taken at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            seen.command        = t_cmd'(res_ch.command);
            seen.pixel_x        = res_ch.pixel_x;
            seen.pixel_y        = res_ch.pixel_y;
            seen.glyph_offset   = res_ch.glyph_offset;
            seen.status         = t_status'(res_ch.status);
            seen.cursor_col_out = res_ch.cursor_col_out;
            seen.cursor_row_out = res_ch.cursor_row_out;
            seen.last           = res_ch.last;
            tracker.check_beat(seen);
        end
    end

    // Result side: random stalls per beat, plus one long hold-off on request
    initial begin
        int n_taken;
        int stall;
        n_taken = 0;
        res_ch.ready <= 1'b0;
        forever begin
            if (hold_request) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end
            stall = fast_take ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            n_taken++;
            if (n_taken % 12 == 0)
                fast_take = ($urandom_range(0, 3) == 0);
        end
    end

    // Offer one request beat and hold it until taken
    task automatic send_item(logic [1:0] kind, logic [CODE_W-1:0] code,
                             logic [CELL_W-1:0] col, logic [CELL_W-1:0] row);
        int gap;
        gap = fast_send ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.kind      <= kind;
        item_ch.char_code <= code;
        item_ch.cell_col  <= col;
        item_ch.cell_row  <= row;
        do @(posedge i_clk); while (!item_ch.ready);
        tracker.take_request(kind, code, col, row);
        if (tracker.n_items % 10 == 0)
            fast_send = ($urandom_range(0, 3) == 0);
    endtask

    // Drop the request valid and wait until every beat has come back
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One register write; the caller lowers valid after the last one
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        tracker.set_reg(idx, data);
    endtask

    function automatic logic [CODE_W-1:0] pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return CODE_W'($urandom_range(32, 126));
        if (r < 72) begin
            case ($urandom_range(0, 3))
                0:       return CODE_W'(CH_NEWLINE);
                1:       return CODE_W'(CH_BACKSPACE);
                2:       return CODE_W'(CH_CR);
                default: return CODE_W'(CH_TAB);
            endcase
        end
        if (r < 80) return CODE_W'($urandom_range(0, 31));
        if (r < 88) return CODE_W'($urandom_range(CODE_ASCII_END, CODE_BYTE_MAX));
        return CODE_W'($urandom);
    endfunction

    task automatic send_random_item();
        int pick, ec, er;
        logic [1:0]        kind;
        logic [CELL_W-1:0] col, row;
        ec   = tracker.visible_cols();
        er   = tracker.visible_rows();
        pick = $urandom_range(0, 99);
        kind = (pick < 50) ? KIND_PUT_CURSOR :
               (pick < 80) ? KIND_PUT_CELL :
               (pick < 91) ? KIND_SET_CURSOR : KIND_CLEAR;
        // Mostly on-screen cells, now and then anywhere in the field
        if (ec > 0 && $urandom_range(0, 7) != 0)
            col = CELL_W'($urandom_range(0, ec - 1));
        else
            col = CELL_W'($urandom_range(0, 255));
        if (er > 0 && $urandom_range(0, 7) != 0)
            row = CELL_W'($urandom_range(0, er - 1));
        else
            row = CELL_W'($urandom_range(0, 255));
        send_item(kind, pick_code(), col, row);
    endtask

    // Reprogram the whole screen, then run random requests under it
    task automatic run_setting(logic [CFG_DAT_W-1:0] gw, logic [CFG_DAT_W-1:0] gh,
                               logic [CFG_DAT_W-1:0] nc, logic [CFG_DAT_W-1:0] nr,
                               int n_req, bit with_hold);
        settle();
        write_reg(REG_GLYPH_WIDTH, gw);
        write_reg(REG_GLYPH_HEIGHT, gh);
        write_reg(REG_TEXT_COLUMNS, nc);
        write_reg(REG_TEXT_ROWS, nr);
        cfg_ch.valid <= 1'b0;
        n_settings++;
        for (int i = 0; i < n_req; i++) begin
            if (with_hold && i == n_req / 3) begin
                fast_send    = 1'b1;
                hold_request = 1'b1;
            end
            send_random_item();
        end
    endtask

    // Main sequence
    initial begin
        tracker      = new();
        fast_send    = 1'b0;
        fast_take    = 1'b0;
        hold_request = 1'b0;
        n_settings   = 1;
        i_rst_n           <= 1'b0;
        item_ch.valid     <= 1'b0;
        item_ch.kind      <= KIND_PUT_CURSOR;
        item_ch.char_code <= '0;
        item_ch.cell_col  <= '0;
        item_ch.cell_row  <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= REG_GLYPH_WIDTH;
        cfg_ch.data       <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening on the reset screen of 80x25 cells
        send_item(KIND_PUT_CURSOR, 16'h0041, 8'd0, 8'd0);      // letter at home
        send_item(KIND_PUT_CELL, 16'hFFFF, 8'd79, 8'd24);      // wide code, wrap and scroll
        send_item(KIND_PUT_CURSOR, 16'd200, 8'd0, 8'd0);       // upper byte refused
        send_item(KIND_PUT_CELL, 16'd128, 8'hFF, 8'hFF);       // code refused before cell
        send_item(KIND_PUT_CELL, 16'h0042, 8'hFF, 8'hFF);      // cell off screen
        send_item(KIND_SET_CURSOR, 16'hFFFF, 8'd80, 8'd0);     // cursor off screen
        send_item(KIND_SET_CURSOR, 16'h0000, 8'd10, 8'd5);
        send_item(KIND_PUT_CURSOR, CODE_W'(CH_NEWLINE), 8'd0, 8'd0);
        send_item(KIND_PUT_CELL, CODE_W'(CH_NEWLINE), 8'd3, 8'd24);  // newline on last row
        send_item(KIND_PUT_CELL, CODE_W'(CH_BACKSPACE), 8'd0, 8'd0); // backspace at home
        send_item(KIND_PUT_CELL, CODE_W'(CH_BACKSPACE), 8'd0, 8'd7); // back onto previous row
        send_item(KIND_PUT_CELL, CODE_W'(CH_BACKSPACE), 8'd5, 8'd3);
        send_item(KIND_PUT_CELL, CODE_W'(CH_CR), 8'd7, 8'd9);
        send_item(KIND_PUT_CURSOR, CODE_W'(CH_TAB), 8'd0, 8'd0);
        send_item(KIND_PUT_CELL, CODE_W'(CH_TAB), 8'd78, 8'd24);     // tab across the corner
        send_item(KIND_PUT_CELL, 16'd0, 8'd0, 8'd0);
        send_item(KIND_PUT_CELL, 16'd127, 8'd40, 8'd12);
        send_item(KIND_PUT_CELL, CODE_BYTE_MAX, 8'd1, 8'd1);
        send_item(KIND_PUT_CELL, 16'd256, 8'd2, 8'd2);
        send_item(KIND_PUT_CELL, 16'd1, 8'd79, 8'd0);          // control glyph, wrap only
        send_item(KIND_CLEAR, 16'hFFFF, 8'hFF, 8'hFF);
        send_item(KIND_SET_CURSOR, 16'h0000, 8'd70, 8'd20);

        // Shrink the screen under the cursor; an unused index is ignored
        settle();
        write_reg(REG_TEXT_COLUMNS, 9'd40);
        write_reg(REG_UNUSED, 9'h1FF);
        cfg_ch.valid <= 1'b0;
        send_item(KIND_PUT_CURSOR, 16'h005A, 8'd0, 8'd0);
        send_item(KIND_PUT_CURSOR, CODE_W'(CH_BACKSPACE), 8'd0, 8'd0);

        // Random requests under a range of screens
        run_setting(9'd1, 9'd1, 9'd1, 9'd1, 15, 1'b0);
        run_setting(9'd32, 9'd32, 9'd256, 9'd256, 30, 1'b1);
        run_setting(9'h1FF, 9'h1FF, 9'h1FF, 9'd300, 20, 1'b0);
        run_setting(9'd8, 9'd16, 9'd0, 9'd25, 8, 1'b0);
        run_setting(9'd5, 9'd7, 9'd13, 9'd6, 25, 1'b0);
        run_setting(9'd8, 9'd16, 9'd80, 9'd0, 8, 1'b0);
        run_setting(CFG_DAT_W'(RST_GLYPH_WIDTH), CFG_DAT_W'(RST_GLYPH_HEIGHT),
                    CFG_DAT_W'(RST_TEXT_COLUMNS), CFG_DAT_W'(RST_TEXT_ROWS),
                    20, 1'b0);

        // Drain and let the block go quiet
        item_ch.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests and %0d result beats across %0d screen settings",
                 tracker.n_items, tracker.n_beats, n_settings);
        $display("with %0d register writes; %0d mismatches found.",
                 tracker.n_writes, tracker.n_errors);
        if (tracker.n_errors == 0) begin
            $display("PASS text_cursor_controller_unit");
        end else begin
            $display("FAIL text_cursor_controller_unit");
        end
        $finish;
    end

endmodule
